>>> src/spq_pkg.sv
// Shared types and default constants for the stable priority queue.
// Used by the interfaces, the cell and the top level; no dependencies.
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdBitsDefault     = 16;
  localparam int unsigned PrioBitsDefault   = 4;
  localparam int unsigned OpcodeBits        = 2;

  // Operation codes of one input transfer
  typedef enum logic [OpcodeBits-1:0] {
    OpEnq = 2'd0,
    OpDeq = 2'd1,
    OpClr = 2'd2,
    OpNop = 2'd3
  } spq_op_e;

  // Action broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_cell_ctrl_t;

endpackage

>>> src/spq_if.sv
// Valid/ready channel interfaces for operation items and result items.
// Depends on spq_pkg for the opcode width.
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int unsigned ID_BITS       = IdBitsDefault,
  parameter int unsigned PRIORITY_BITS = PrioBitsDefault
);
  logic                     valid;
  logic                     ready;
  logic [OpcodeBits-1:0]    opcode;
  logic [ID_BITS-1:0]       item_id;
  logic [PRIORITY_BITS-1:0] item_priority;

  modport source (output valid, output opcode, output item_id, output item_priority,
                  input ready);
  modport sink   (input valid, input opcode, input item_id, input item_priority,
                  output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
#(
  parameter int unsigned ID_BITS  = IdBitsDefault,
  parameter int unsigned OCC_BITS = $clog2(QueueDepthDefault + 1)
);
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  removed_id;
  logic                removed_valid;
  logic [ID_BITS-1:0]  head_id;
  logic                queue_empty;
  logic                entry_dropped;
  logic [OCC_BITS-1:0] occupancy;

  modport source (output valid, output removed_id, output removed_valid, output head_id,
                  output queue_empty, output entry_dropped, output occupancy,
                  input ready);
  modport sink   (input valid, input removed_id, input removed_valid, input head_id,
                  input queue_empty, input entry_dropped, input occupancy,
                  output ready);
endinterface

>>> src/stable_priority_queue_core.sv
// Stable sorted priority queue: a chain of compare-and-shift cells.
// The result of an accepted operation is in the output register in the next cycle.
// One operation per cycle unless out_o stalls; all cells compare and shift in parallel.
// Reset clears the occupancy count and the output valid; slot contents are not cleared.
// Input is accepted while the output register is empty or being drained.
// Depends on spq_pkg, spq_if and spq_cell.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDefault,
  parameter int unsigned ID_BITS       = IdBitsDefault,
  parameter int unsigned PRIORITY_BITS = PrioBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  logic [CntBits-1:0] count_q, count_d;
  logic               accept;
  spq_op_e            op;
  logic               full, empty;
  logic               enq_go, deq_go, clr_go, drop;
  spq_cell_ctrl_t     ctrl;

  logic [ID_BITS-1:0]       cell_id   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       cell_id_d [QUEUE_DEPTH];
  logic                     cell_gt   [QUEUE_DEPTH];
  logic                     occupied  [QUEUE_DEPTH];

  logic               out_valid_q;
  logic [ID_BITS-1:0] removed_id_q, head_id_q;
  logic               removed_valid_q, queue_empty_q, entry_dropped_q;
  logic [CntBits-1:0] occupancy_q;

  // Accept while the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = spq_op_e'(in_i.opcode);
  assign full       = (count_q == CntBits'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  assign enq_go = accept && (op == OpEnq) && !full;
  assign drop   = accept && (op == OpEnq) && full;
  assign deq_go = accept && (op == OpDeq) && !empty;
  assign clr_go = accept && (op == OpClr);

  assign ctrl.enq = enq_go;
  assign ctrl.deq = deq_go;

  // Update the occupancy count: up on enqueue, down on dequeue, zero on clear
  always_comb begin
    count_d = count_q;
    if (enq_go) begin
      count_d = count_q + CntBits'(1);
    end else if (deq_go) begin
      count_d = count_q - CntBits'(1);
    end else if (clr_go) begin
      count_d = '0;
    end
  end

  // Build the cell chain; cell 0 is the front
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                     left_gt;
    logic [ID_BITS-1:0]       left_id, right_id;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;

    assign occupied[g] = (CntBits'(g) < count_q);

    if (g == 0) begin : g_first
      assign left_gt   = 1'b0;
      assign left_id   = '0;
      assign left_prio = '0;
    end else begin : g_inner_left
      assign left_gt   = cell_gt[g-1];
      assign left_id   = cell_id[g-1];
      assign left_prio = cell_prio[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_id   = cell_id[g];
      assign right_prio = cell_prio[g];
    end else begin : g_inner_right
      assign right_id   = cell_id[g+1];
      assign right_prio = cell_prio[g+1];
    end

    spq_cell #(
      .ID_BITS      (ID_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[g]),
      .new_id_i    (in_i.item_id),
      .new_prio_i  (in_i.item_priority),
      .left_gt_i   (left_gt),
      .left_id_i   (left_id),
      .left_prio_i (left_prio),
      .right_id_i  (right_id),
      .right_prio_i(right_prio),
      .gt_o        (cell_gt[g]),
      .id_o        (cell_id[g]),
      .prio_o      (cell_prio[g]),
      .id_d_o      (cell_id_d[g])
    );
  end

  // Hold the count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture result payload on each accepted transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_id_q    <= deq_go ? cell_id[0] : '0;
      removed_valid_q <= deq_go;
      head_id_q       <= (count_d != '0) ? cell_id_d[0] : '0;
      queue_empty_q   <= (count_d == '0);
      entry_dropped_q <= drop;
      occupancy_q     <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_id    = removed_id_q;
  assign out_o.removed_valid = removed_valid_q;
  assign out_o.head_id       = head_id_q;
  assign out_o.queue_empty   = queue_empty_q;
  assign out_o.entry_dropped = entry_dropped_q;
  assign out_o.occupancy     = occupancy_q;

`ifndef ASSERT_OFF
  // Count never exceeds the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(QUEUE_DEPTH))
    else $error("occupancy count beyond depth");

  // A removal lowers the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_go |=> (count_q == $past(count_q) - CntBits'(1)))
    else $error("dequeue did not lower occupancy by one");

  // A dropped entry reports a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && entry_dropped_q) |-> (occupancy_q == CntBits'(QUEUE_DEPTH)))
    else $error("entry dropped while queue not full");

  // Empty flag agrees with occupancy in the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (queue_empty_q == (occupancy_q == '0)))
    else $error("empty flag disagrees with occupancy");

  // Occupied cells stay sorted by priority number
  for (genvar a = 1; a < QUEUE_DEPTH; a++) begin : g_sorted_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      occupied[a] |-> (cell_prio[a-1] <= cell_prio[a]))
      else $error("cell chain out of priority order");
  end
`endif

endmodule

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an (id, priority) pair and shifts it
// toward either neighbor. Depends on spq_pkg for the control struct.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned ID_BITS       = IdBitsDefault,
  parameter int unsigned PRIORITY_BITS = PrioBitsDefault
) (
  input  logic                     clk_i,
  input  spq_cell_ctrl_t           ctrl_i,
  input  logic                     occupied_i,
  input  logic [ID_BITS-1:0]       new_id_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                     left_gt_i,
  input  logic [ID_BITS-1:0]       left_id_i,
  input  logic [PRIORITY_BITS-1:0] left_prio_i,
  input  logic [ID_BITS-1:0]       right_id_i,
  input  logic [PRIORITY_BITS-1:0] right_prio_i,
  output logic                     gt_o,
  output logic [ID_BITS-1:0]       id_o,
  output logic [PRIORITY_BITS-1:0] prio_o,
  output logic [ID_BITS-1:0]       id_d_o
);

  logic [ID_BITS-1:0]       id_q, id_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;

  // Held entry ranks behind the new one
  assign gt_o = occupied_i && (prio_q > new_prio_i);

  // Select shift from left, take new entry, shift from right, or hold
  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    if (ctrl_i.enq) begin
      if (left_gt_i) begin
        id_d   = left_id_i;
        prio_d = left_prio_i;
      end else if (gt_o || !occupied_i) begin
        id_d   = new_id_i;
        prio_d = new_prio_i;
      end
    end else if (ctrl_i.deq) begin
      id_d   = right_id_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;
  assign id_d_o = id_d;

endmodule

>>> verif/spq_status_checker.sv
// Status checker for the stable priority queue: watches both channels.
// Mirrors the queue contents, predicts each status transfer and compares it.
// Depends on spq_pkg and the spq_in_if / spq_out_if interfaces.
`timescale 1ns / 1ps

module spq_status_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_in_if           in_mon,
  spq_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Depth   = QueueDepthDefault;
  localparam int unsigned OccBits = $clog2(QueueDepthDefault + 1);

  typedef struct packed {
    logic [IdBitsDefault-1:0] removed_id;
    logic                     removed_valid;
    logic [IdBitsDefault-1:0] head_id;
    logic                     queue_empty;
    logic                     entry_dropped;
    logic [OccBits-1:0]       occupancy;
  } queue_status_t;

  // Mirror of the sorted slots, slot 0 is the front
  logic [IdBitsDefault-1:0]   mirror_id   [Depth];
  logic [PrioBitsDefault-1:0] mirror_prio [Depth];
  int unsigned                mirror_count;

  queue_status_t status_q [$];

  // Apply one operation to the mirror and return the status it yields
  function automatic queue_status_t apply_queue_op(spq_op_e op,
                                                   logic [IdBitsDefault-1:0] id,
                                                   logic [PrioBitsDefault-1:0] prio);
    queue_status_t st;
    int unsigned   pos;
    st = '0;
    case (op)
      OpEnq: begin
        if (mirror_count >= Depth) begin
          st.entry_dropped = 1'b1;
        end else begin
          // Insert behind every entry of equal or smaller priority number
          pos = mirror_count;
          for (int unsigned i = 0; i < mirror_count; i++) begin
            if (mirror_prio[i] > prio) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = mirror_count; i > pos; i--) begin
            mirror_id[i]   = mirror_id[i-1];
            mirror_prio[i] = mirror_prio[i-1];
          end
          mirror_id[pos]   = id;
          mirror_prio[pos] = prio;
          mirror_count++;
        end
      end
      OpDeq: begin
        if (mirror_count > 0) begin
          st.removed_id    = mirror_id[0];
          st.removed_valid = 1'b1;
          for (int unsigned i = 1; i < mirror_count; i++) begin
            mirror_id[i-1]   = mirror_id[i];
            mirror_prio[i-1] = mirror_prio[i];
          end
          mirror_count--;
        end
      end
      OpClr: begin
        mirror_count = 0;
      end
      default: ;
    endcase
    st.head_id     = (mirror_count > 0) ? mirror_id[0] : '0;
    st.queue_empty = (mirror_count == 0);
    st.occupancy   = OccBits'(mirror_count);
    return st;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // Compare drained status first, then record the newly accepted operation
  always @(posedge clk_i or negedge rst_ni) begin
    queue_status_t want;
    if (!rst_ni) begin
      mirror_count = 0;
      status_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no operation outstanding");
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("removed_id",    32'(want.removed_id),    32'(out_mon.removed_id));
          check_field("removed_valid", 32'(want.removed_valid), 32'(out_mon.removed_valid));
          check_field("head_id",       32'(want.head_id),       32'(out_mon.head_id));
          check_field("queue_empty",   32'(want.queue_empty),   32'(out_mon.queue_empty));
          check_field("entry_dropped", 32'(want.entry_dropped), 32'(out_mon.entry_dropped));
          check_field("occupancy",     32'(want.occupancy),     32'(out_mon.occupancy));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        status_q.push_back(apply_queue_op(spq_op_e'(in_mon.opcode), in_mon.item_id,
                                          in_mon.item_priority));
      end
      pending_o = status_q.size();
    end
  end

endmodule

>>> verif/stable_priority_queue_core_test.sv
// Top of the stable priority queue test: clock, reset, stimulus and verdict.
// Drives operations with random idling and hold-offs; spq_status_checker judges results.
// Depends on spq_pkg, the spq interfaces, the core and spq_status_checker.
`timescale 1ns / 1ps

module stable_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_taken;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_left;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  stable_priority_queue_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  spq_status_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Note each input transfer for the driver to pick up at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // Receiver: hold off while a stretch is requested, else stall at random
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("stable_priority_queue_core_test: errors");
    $finish;
  end

  // Offer one operation after a random gap and hold it until transferred
  task automatic send_op(spq_op_e op, logic [15:0] id, logic [3:0] prio);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.item_id       <= id;
    in_ch.item_priority <= prio;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // Random operations; enq_pct steers the queue toward full or empty
  task automatic send_random(int unsigned count, int unsigned enq_pct);
    int unsigned pick;
    spq_op_e     op;
    logic [3:0]  prio;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 2) op = OpClr;
      else if (pick < 5) op = OpNop;
      else if (pick < enq_pct) op = OpEnq;
      else op = OpDeq;
      // Narrow priorities half the time so ties are common
      prio = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      send_op(op, 16'($urandom_range(16'hFFFF)), prio);
    end
  endtask

  // Idle the sender until every outstanding status has arrived
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OpNop;
    in_ch.item_id       = '0;
    in_ch.item_priority = '0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    rx_hold_left        = 0;
    rst_ni              = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty dequeue and no-op, fill past full with ties, then clear
    send_op(OpDeq, 16'h1234, 4'hF);
    send_op(OpNop, 16'hFFFF, 4'hF);
    for (int unsigned k = 0; k < 17; k++) begin
      send_op(OpEnq, (k == 1) ? 16'h0000 : 16'hFFFF - 16'(k * 16'h0F0F),
              4'((k % 4) * 5));
    end
    send_op(OpNop, 16'h0000, 4'h0);
    send_op(OpDeq, 16'h0000, 4'h0);
    send_op(OpClr, 16'hFFFF, 4'hF);
    send_op(OpDeq, 16'h0000, 4'h0);
    send_op(OpEnq, 16'hA5A5, 4'h0);
    drain();

    // No idling, with a long receiver hold-off while the sender keeps offering
    send_random(210, 60);
    rx_hold_left = 300;
    send_random(40, 60);
    send_random(170, 35);
    drain();

    // Sender idle most cycles
    tx_idle_pct = 77;
    send_random(210, 60);
    send_random(210, 35);
    drain();

    // Receiver stalling most cycles
    tx_idle_pct  = 0;
    rx_stall_pct = 77;
    send_random(210, 60);
    send_random(210, 35);
    drain();

    // Both sides idling
    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    send_random(210, 60);
    send_random(210, 35);
    drain();

    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("stable_priority_queue_core_test: clean");
    end else begin
      $display("stable_priority_queue_core_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
src/spq_pkg.sv
src/spq_if.sv
src/spq_cell.sv
src/stable_priority_queue_core.sv
verif/spq_status_checker.sv
verif/stable_priority_queue_core_test.sv
